FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/iouvm_pkg.sv
// ----------------------------------------------------------------------------
// iouvm_pkg
// Shared types and codes of the interval IoU verdict matcher.
// ----------------------------------------------------------------------------
package iouvm_pkg;
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_MATCH = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic CFG_THRESH = 1'b0;
	localparam logic CFG_CARRY  = 1'b1;

	// request travelling down the cell chain
	typedef struct packed {
		logic        vld;
		logic [32:0] ws;
		logic [32:0] we;
		logic [16:0] thr;
		logic        found;
		logic [47:0] b_rt;
		logic [32:0] b_i;
		logic [33:0] b_u;
		logic [31:0] b_key;
		logic        b_app;
		logic [7:0]  b_rsn;
		logic [15:0] b_ver;
		logic [10:0] b_idx;
	} iouvm_req_t;
endpackage

FILE: hdl/iouvm_cell.sv
// ----------------------------------------------------------------------------
// iouvm_cell
// One table entry: stores a window and verdict, scores the passing request.
// The cell computes this entry's IoU in stage one and merges it into the
// running best in stage two, then hands the request to its neighbor.
// ----------------------------------------------------------------------------
module iouvm_cell import iouvm_pkg::*; #(
	parameter int IDX_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  my_idx,
	input  logic              wr,
	input  logic [31:0]       wr_start,
	input  logic [31:0]       wr_end,
	input  logic [47:0]       wr_rt,
	input  logic [31:0]       wr_key,
	input  logic              wr_app,
	input  logic [7:0]        wr_rsn,
	input  logic [15:0]       wr_ver,
	input  logic              live,
	input  logic              take,
	input  logic              clr,
	input  iouvm_req_t        req_in,
	output iouvm_req_t        req_out,
	output logic              untaken
);
	logic [31:0] start_q, end_q, key_q;
	logic [47:0] rt_q;
	logic        app_q, taken_q;
	logic [7:0]  rsn_q;
	logic [15:0] ver_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			start_q <= wr_start;
			end_q   <= (wr_end < wr_start) ? wr_start : wr_end;
			rt_q    <= wr_rt;
			key_q   <= wr_key;
			app_q   <= wr_app;
			rsn_q   <= wr_rsn;
			ver_q   <= wr_ver;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
		end else if (wr || clr) begin
			taken_q <= 1'b0;
		end else if (take) begin
			taken_q <= 1'b1;
		end
	end

	assign untaken = live && !taken_q;

	// stage 1: intersection and union
	logic [32:0] lo, hi, it, un_a;
	logic [33:0] un;
	always_comb begin
		lo = (req_in.ws > {1'b0, start_q}) ? req_in.ws : {1'b0, start_q};
		hi = (req_in.we < {1'b0, end_q}) ? req_in.we : {1'b0, end_q};
		it = (hi > lo) ? hi - lo : 33'd0;
		un_a = req_in.we - req_in.ws;
		un = {1'b0, un_a} + {2'b0, end_q} - {2'b0, start_q} - {1'b0, it};
	end

	iouvm_req_t r_s1;
	logic        vld_s1;
	logic [32:0] it_s1;
	logic [33:0] un_s1;
	logic        cand_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req_in.vld;
		end
	end
	always_ff @(posedge clk) begin
		r_s1 <= req_in;
		cand_s1 <= live && !taken_q;
		if (un == 34'd0) begin
			it_s1 <= 33'd0;
			un_s1 <= 34'd1;
		end else begin
			it_s1 <= it;
			un_s1 <= un;
		end
	end

	// stage 2: threshold and ranking (products up to 34x34)
	logic [49:0] lhs;
	logic [50:0] rhs;
	logic [67:0] p_new, p_old;
	logic        pass, better;
	always_comb begin
		lhs = {it_s1, 16'd0} + 50'd0;
		rhs = r_s1.thr * un_s1;
		pass = cand_s1 && ({1'b0, lhs} >= rhs);
		p_new = {1'b0, it_s1} * r_s1.b_u;
		p_old = {1'b0, r_s1.b_i} * un_s1;
		better = !r_s1.found || (rt_q > r_s1.b_rt) ||
			((rt_q == r_s1.b_rt) && (p_new > p_old));
		req_out = r_s1;
		req_out.vld = vld_s1;
		if (pass && better) begin
			req_out.found = 1'b1;
			req_out.b_rt  = rt_q;
			req_out.b_i   = it_s1;
			req_out.b_u   = un_s1;
			req_out.b_key = key_q;
			req_out.b_app = app_q;
			req_out.b_rsn = rsn_q;
			req_out.b_ver = ver_q;
			req_out.b_idx = 11'(my_idx);
		end
	end
endmodule

FILE: hdl/interval_iou_verdict_matcher.sv
// ----------------------------------------------------------------------------
// interval_iou_verdict_matcher
// Greedy interval-IoU matching of detections against reviewed windows.
// ----------------------------------------------------------------------------
// Each table entry lives in a cell of a chain. A match request enters the
// head of the chain and moves one cell per cycle (each cell registers the IoU
// terms and does threshold and ranking on the way out), so a match result is
// registered from the tail after the request has passed every cell. Loads,
// end-media, unknown requests and matches with carry off give their result
// in the cycle after acceptance. One request is worked at a time; a new
// request is taken no earlier than the cycle in which the previous result is
// accepted. Table contents are undefined until loaded.
module interval_iou_verdict_matcher import iouvm_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] start_ms,
	input  logic [31:0] end_ms,
	input  logic [47:0] review_time,
	input  logic [31:0] entry_key,
	input  logic        approved_in,
	input  logic [7:0]  reason_in,
	input  logic [15:0] version_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        matched,
	output logic [31:0] match_key,
	output logic        match_approved,
	output logic [7:0]  match_reason,
	output logic [15:0] match_version,
	output logic [31:0] approved_total,
	output logic [31:0] rejected_total,
	output logic [31:0] pending_total,
	output logic [31:0] unmatched_total
);
`include "assert_macros.svh"
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [16:0] thr_q;
	logic        carry_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 17'd32768;
			carry_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESH: thr_q   <= cfg_data;
				CFG_CARRY:  carry_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [1:0]        st_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       app_q, rej_q, pend_q, unm_q;
	logic              accept, ov_q, ov_set;
	logic [32:0]       ws_n, we_n;

	assign in_stall = (st_q != ST_IDLE) || (ov_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign ws_n = {1'b0, start_ms};
	assign we_n = (end_ms < start_ms) ? {1'b0, start_ms} : {1'b0, end_ms};

	iouvm_req_t chain [TABLE_DEPTH+1];
	iouvm_req_t head;
	logic [TABLE_DEPTH-1:0] unt;
	logic [TABLE_DEPTH-1:0] wr_v, take_v;
	logic do_take, do_clr;
	logic [IDX_W-1:0] take_idx;

	always_comb begin
		head = '0;
		head.vld = accept && (operation == OP_MATCH) && carry_q;
		head.ws  = ws_n;
		head.we  = we_n;
		head.thr = thr_q;
		head.b_u = 34'd1;
	end
	assign chain[0] = head;

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			assign wr_v[g] = accept && (operation == OP_LOAD) &&
				(count_q == CNT_W'(g));
			assign take_v[g] = do_take && (take_idx == IDX_W'(g));
			iouvm_cell #(.IDX_W(IDX_W)) u_cell (
				.clk(clk), .arst_n(arst_n), .my_idx(IDX_W'(g)),
				.wr(wr_v[g]), .wr_start(start_ms), .wr_end(end_ms),
				.wr_rt(review_time), .wr_key(entry_key), .wr_app(approved_in),
				.wr_rsn(reason_in), .wr_ver(version_in),
				.live(count_q > CNT_W'(g)), .take(take_v[g]), .clr(do_clr),
				.req_in(chain[g]), .req_out(chain[g+1]), .untaken(unt[g])
			);
		end
	endgenerate

	logic [CNT_W-1:0] untaken_n;
	always_comb begin
		untaken_n = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) untaken_n = untaken_n + CNT_W'(unt[k]);
	end

	iouvm_req_t tail;
	assign tail = chain[TABLE_DEPTH];
	assign do_take = (st_q == ST_RUN) && tail.vld && tail.found;
	assign take_idx = tail.b_idx[IDX_W-1:0];
	assign do_clr = accept && (operation == OP_END);

	function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign ov_set = (accept && !((operation == OP_MATCH) && carry_q)) ||
		((st_q == ST_RUN) && tail.vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_set) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; count_q <= '0;
			app_q <= '0; rej_q <= '0; pend_q <= '0; unm_q <= '0;
			status <= 1'b0; matched <= 1'b0; match_key <= '0;
			match_approved <= 1'b0; match_reason <= '0; match_version <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						status <= 1'b0; matched <= 1'b0; match_key <= '0;
						match_approved <= 1'b0; match_reason <= '0; match_version <= '0;
						priority case (operation)
							OP_LOAD: begin
								if (count_q == CNT_W'(TABLE_DEPTH)) status <= 1'b1;
								else count_q <= count_q + 1'b1;
							end
							OP_MATCH: begin
								if (carry_q) st_q <= ST_RUN;
								else pend_q <= sat_inc(pend_q, 32'd1);
							end
							OP_END: begin
								if (carry_q) unm_q <= sat_inc(unm_q, 32'(untaken_n));
								count_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (tail.vld) begin
						st_q <= ST_IDLE;
						matched <= tail.found;
						if (tail.found) begin
							match_key <= tail.b_key; match_approved <= tail.b_app;
							match_reason <= tail.b_rsn; match_version <= tail.b_ver;
							if (tail.b_app) app_q <= sat_inc(app_q, 32'd1);
							else rej_q <= sat_inc(rej_q, 32'd1);
						end else begin
							pend_q <= sat_inc(pend_q, 32'd1);
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign approved_total = app_q;
	assign rejected_total = rej_q;
	assign pending_total = pend_q;
	assign unmatched_total = unm_q;

	`ASSERT_IMP(a_no_accept_busy, clk, arst_n, st_q == ST_RUN, !accept)
	`ASSERT_IMP(a_count_le, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`ASSERT_NXT(a_run_no_out, clk, arst_n, accept && operation == OP_MATCH && carry_q, st_q == ST_RUN)
endmodule
